// File: rtl/dlr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dashed line rasterizer package
// Shared widths, command codes, register indexes and the item types that
// travel between the front part, the command queue and the walker.
// ----------------------------------------------------------------------------
package dlr_pkg;

	localparam int CW = 16;	// coordinate port width
	localparam int DW = CW + 1;	// absolute distance width
	localparam int EW = CW + 3;	// error term width
	localparam int PW = 9;	// dash counter width
	localparam int LW = 8;	// dash and gap length width
	localparam int IW = 3;	// register index width

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	localparam logic [IW-1:0] REG_DASH_LENGTH = 3'd0;
	localparam logic [IW-1:0] REG_GAP_LENGTH  = 3'd1;
	localparam logic [IW-1:0] REG_CLIP_LEFT   = 3'd2;
	localparam logic [IW-1:0] REG_CLIP_TOP    = 3'd3;
	localparam logic [IW-1:0] REG_CLIP_RIGHT  = 3'd4;
	localparam logic [IW-1:0] REG_CLIP_BOTTOM = 3'd5;

	typedef struct packed {
		logic                 cmd;
		logic signed [CW-1:0] x0;
		logic signed [CW-1:0] y0;
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y1;
		logic [DW-1:0]        dx;
		logic [DW-1:0]        dy;
		logic                 x_neg;
		logic                 y_neg;
	} cmd_entry_t;

	typedef struct packed {
		logic [LW-1:0]        dash_length;
		logic [LW-1:0]        gap_length;
		logic signed [CW-1:0] clip_left;
		logic signed [CW-1:0] clip_top;
		logic signed [CW-1:0] clip_right;
		logic signed [CW-1:0] clip_bottom;
	} cfg_t;

	typedef struct packed {
		logic                 active;
		logic signed [CW-1:0] pixel_x;
		logic signed [CW-1:0] pixel_y;
		logic                 draw;
		logic                 last;
	} result_t;

endpackage
`default_nettype wire

// File: rtl/dlr_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dashed line rasterizer small queue
// Register based first-in first-out queue with push and pop in one cycle.
// ----------------------------------------------------------------------------
module dlr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

// File: rtl/dlr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dashed line rasterizer front part
// Passes the command on and prepares the endpoints, distances and directions.
// ----------------------------------------------------------------------------
module dlr_front #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                     cmd,
	input  wire logic signed [dlr_pkg::CW-1:0] start_x,
	input  wire logic signed [dlr_pkg::CW-1:0] start_y,
	input  wire logic signed [dlr_pkg::CW-1:0] end_x,
	input  wire logic signed [dlr_pkg::CW-1:0] end_y,
	output dlr_pkg::cmd_entry_t           entry
);

	logic signed [COORD_BITS-1:0] sx_c;
	logic signed [COORD_BITS-1:0] sy_c;
	logic signed [COORD_BITS-1:0] ex_c;
	logic signed [COORD_BITS-1:0] ey_c;
	logic signed [dlr_pkg::CW-1:0] x0;
	logic signed [dlr_pkg::CW-1:0] y0;
	logic signed [dlr_pkg::CW-1:0] x1;
	logic signed [dlr_pkg::CW-1:0] y1;
	logic signed [dlr_pkg::DW-1:0] diff_x;
	logic signed [dlr_pkg::DW-1:0] diff_y;

	assign sx_c = start_x[COORD_BITS-1:0];
	assign sy_c = start_y[COORD_BITS-1:0];
	assign ex_c = end_x[COORD_BITS-1:0];
	assign ey_c = end_y[COORD_BITS-1:0];
	assign x0   = dlr_pkg::CW'(sx_c);
	assign y0   = dlr_pkg::CW'(sy_c);
	assign x1   = dlr_pkg::CW'(ex_c);
	assign y1   = dlr_pkg::CW'(ey_c);

	assign diff_x = dlr_pkg::DW'(x1) - dlr_pkg::DW'(x0);
	assign diff_y = dlr_pkg::DW'(y1) - dlr_pkg::DW'(y0);

	always_comb begin
		entry       = '0;
		entry.cmd   = cmd;
		entry.x0    = x0;
		entry.y0    = y0;
		entry.x1    = x1;
		entry.y1    = y1;
		entry.x_neg = !(x0 < x1);
		entry.y_neg = !(y0 < y1);
		entry.dx    = entry.x_neg ? dlr_pkg::DW'(-diff_x) : dlr_pkg::DW'(diff_x);
		entry.dy    = entry.y_neg ? dlr_pkg::DW'(-diff_y) : dlr_pkg::DW'(diff_y);
	end

endmodule
`default_nettype wire

// File: rtl/dlr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dashed line rasterizer walker
// Holds the line state and turns one queued command into one pixel result.
// ----------------------------------------------------------------------------
module dlr_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	input  wire dlr_pkg::cmd_entry_t entry,
	input  wire dlr_pkg::cfg_t       cfg,
	input  wire logic                out_full,
	output logic                     issue,
	output dlr_pkg::result_t         res,
	output logic                     busy
);

	localparam int CW = dlr_pkg::CW;
	localparam int DW = dlr_pkg::DW;
	localparam int EW = dlr_pkg::EW;
	localparam int PW = dlr_pkg::PW;

	logic                 busy_q;
	logic signed [CW-1:0] cur_x_q;
	logic signed [CW-1:0] cur_y_q;
	logic signed [CW-1:0] tgt_x_q;
	logic signed [CW-1:0] tgt_y_q;
	logic [DW-1:0]        dx_q;
	logic [DW-1:0]        dy_q;
	logic                 x_neg_q;
	logic                 y_neg_q;
	logic signed [EW-1:0] err_q;
	logic [PW-1:0]        pos_q;

	logic                 is_start;
	logic                 emit;
	logic [PW-1:0]        pos_inc;
	logic [PW-1:0]        period;
	logic signed [EW:0]   e2;
	logic signed [EW:0]   dx_e;
	logic signed [EW:0]   dy_e;
	logic                 move_x;
	logic                 move_y;
	logic signed [CW-1:0] nx;
	logic signed [CW-1:0] ny;
	logic signed [CW-1:0] tx;
	logic signed [CW-1:0] ty;
	logic signed [EW-1:0] n_err;
	logic [PW-1:0]        n_pos;
	logic                 in_clip;
	logic                 at_end;

	assign issue    = q_valid && !out_full;
	assign is_start = (entry.cmd == dlr_pkg::CMD_START);
	assign emit     = is_start || busy_q;
	assign busy     = busy_q;

	assign pos_inc = pos_q + 1'b1;
	assign period  = PW'(cfg.dash_length) + PW'(cfg.gap_length);
	assign e2      = {err_q, 1'b0};
	assign dx_e    = $signed((EW+1)'(dx_q));
	assign dy_e    = $signed((EW+1)'(dy_q));
	assign move_x  = e2 > -dy_e;
	assign move_y  = e2 < dx_e;

	always_comb begin
		if (is_start) begin
			nx    = entry.x0;
			ny    = entry.y0;
			tx    = entry.x1;
			ty    = entry.y1;
			n_err = $signed(EW'(entry.dx)) - $signed(EW'(entry.dy));
			n_pos = '0;
		end else begin
			nx    = cur_x_q;
			ny    = cur_y_q;
			tx    = tgt_x_q;
			ty    = tgt_y_q;
			n_err = err_q;
			n_pos = (pos_inc >= period) ? '0 : pos_inc;
			if (move_x) begin
				nx    = x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
				n_err = n_err - $signed(EW'(dy_q));
			end
			if (move_y) begin
				ny    = y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
				n_err = n_err + $signed(EW'(dx_q));
			end
		end
	end

	assign in_clip = (nx >= cfg.clip_left) && (nx <= cfg.clip_right) &&
	                 (ny >= cfg.clip_top) && (ny <= cfg.clip_bottom);
	assign at_end  = (nx == tx) && (ny == ty);

	always_comb begin
		res = '0;
		if (emit) begin
			res.active  = 1'b1;
			res.pixel_x = nx;
			res.pixel_y = ny;
			res.draw    = (n_pos < PW'(cfg.dash_length)) && in_clip;
			res.last    = at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			tgt_x_q <= '0;
			tgt_y_q <= '0;
			dx_q    <= '0;
			dy_q    <= '0;
			x_neg_q <= 1'b0;
			y_neg_q <= 1'b0;
			err_q   <= '0;
			pos_q   <= '0;
		end else if (issue && emit) begin
			busy_q  <= !at_end;
			cur_x_q <= nx;
			cur_y_q <= ny;
			tgt_x_q <= tx;
			tgt_y_q <= ty;
			err_q   <= n_err;
			pos_q   <= n_pos;
			if (is_start) begin
				dx_q    <= entry.dx;
				dy_q    <= entry.dy;
				x_neg_q <= entry.x_neg;
				y_neg_q <= entry.y_neg;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/dashed_line_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dashed line rasterizer
// Bresenham line walker with a dash pattern and an inclusive clip rectangle.
// ----------------------------------------------------------------------------
// Items enter through push/full: cmd 0 starts a line from start and end
// points, cmd 1 steps one pixel. Every item gives exactly one result, read
// through empty/pop: active, pixel_x, pixel_y, draw and last.
// An accepted item is queued in the command queue, then taken by the walker,
// whose result is written into the result queue and read from its head on
// the result ports; a full result queue holds the walker.
// The walker takes one queued item per cycle while the result queue has
// space, so the block sustains one item per clock while the receiver keeps
// popping; the walker updates its error term and dash counter per item.
// When the receiver stalls, the two-entry result queue fills, the walker
// holds, the two-entry command queue fills and full rises.
// Reset empties both queues, ends any line and loads the register defaults:
// dash 6, gap 4, clip rectangle 0..32767 on both axes.
// Registers are written through wr_en, wr_index and wr_data with no wait.
// ----------------------------------------------------------------------------
module dashed_line_rasterizer #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic                          cmd,
	input  wire logic signed [dlr_pkg::CW-1:0] start_x,
	input  wire logic signed [dlr_pkg::CW-1:0] start_y,
	input  wire logic signed [dlr_pkg::CW-1:0] end_x,
	input  wire logic signed [dlr_pkg::CW-1:0] end_y,
	output logic                               empty,
	input  wire logic                          pop,
	output logic                               active,
	output logic signed [dlr_pkg::CW-1:0]      pixel_x,
	output logic signed [dlr_pkg::CW-1:0]      pixel_y,
	output logic                               draw,
	output logic                               last,
	input  wire logic                          wr_en,
	input  wire logic [dlr_pkg::IW-1:0]        wr_index,
	input  wire logic [dlr_pkg::CW-1:0]        wr_data
);

	localparam int QW = $bits(dlr_pkg::cmd_entry_t);
	localparam int RW = $bits(dlr_pkg::result_t);

	dlr_pkg::cfg_t       cfg_q;
	dlr_pkg::cmd_entry_t front_entry;
	dlr_pkg::cmd_entry_t q_entry;
	dlr_pkg::result_t    back_res;
	dlr_pkg::result_t    out_res;
	logic [QW-1:0]       q_rdata;
	logic [RW-1:0]       out_rdata;
	logic                q_empty;
	logic                out_full;
	logic                issue;
	logic                walker_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dash_length <= dlr_pkg::LW'(6);
			cfg_q.gap_length  <= dlr_pkg::LW'(4);
			cfg_q.clip_left   <= '0;
			cfg_q.clip_top    <= '0;
			cfg_q.clip_right  <= dlr_pkg::CW'(32767);
			cfg_q.clip_bottom <= dlr_pkg::CW'(32767);
		end else if (wr_en) begin
			unique case (wr_index)
				dlr_pkg::REG_DASH_LENGTH: cfg_q.dash_length <= wr_data[dlr_pkg::LW-1:0];
				dlr_pkg::REG_GAP_LENGTH:  cfg_q.gap_length  <= wr_data[dlr_pkg::LW-1:0];
				dlr_pkg::REG_CLIP_LEFT:   cfg_q.clip_left   <= wr_data;
				dlr_pkg::REG_CLIP_TOP:    cfg_q.clip_top    <= wr_data;
				dlr_pkg::REG_CLIP_RIGHT:  cfg_q.clip_right  <= wr_data;
				dlr_pkg::REG_CLIP_BOTTOM: cfg_q.clip_bottom <= wr_data;
				default: begin
				end
			endcase
		end
	end

	dlr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.cmd     (cmd),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.entry   (front_entry)
	);

	dlr_fifo #(
		.WIDTH(QW),
		.DEPTH(2)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_entry),
		.full   (full),
		.pop    (issue),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign q_entry = q_rdata;

	dlr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (!q_empty),
		.entry    (q_entry),
		.cfg      (cfg_q),
		.out_full (out_full),
		.issue    (issue),
		.res      (back_res),
		.busy     (walker_busy)
	);

	dlr_fifo #(
		.WIDTH(RW),
		.DEPTH(2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (issue),
		.wdata  (back_res),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign out_res = out_rdata;
	assign active  = out_res.active;
	assign pixel_x = out_res.pixel_x;
	assign pixel_y = out_res.pixel_y;
	assign draw    = out_res.draw;
	assign last    = out_res.last;

	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !q_empty)
		else $error("accepted item missing from command queue");

	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !active) |-> (pixel_x == '0 && pixel_y == '0 && !draw && !last))
		else $error("inactive result carries nonzero fields");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && back_res.last) |=> !walker_busy)
		else $error("line still busy after its end point");

	a_issue_space: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (!out_full && !q_empty))
		else $error("walker issued without queue space or command");

endmodule
`default_nettype wire
